[hdl/assert_macros.svh]
// Assertion helpers used by the RTL datapath; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define CDLL_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define CDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/cdll_pkg.sv]
package cdll_pkg;

	localparam int CAPACITY_DEF   = 256;
	localparam int VALUE_BITS_DEF = 32;

	localparam logic [2:0] OP_INS_BEFORE = 3'd0;
	localparam logic [2:0] OP_INS_AFTER  = 3'd1;
	localparam logic [2:0] OP_DELETE     = 3'd2;
	localparam logic [2:0] OP_READ       = 3'd3;
	localparam logic [2:0] OP_GO_FIRST   = 3'd4;
	localparam logic [2:0] OP_GO_LAST    = 3'd5;
	localparam logic [2:0] OP_MOVE       = 3'd6;
	localparam logic [2:0] OP_SEARCH     = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	typedef logic [4:0] cmd_t;

	localparam cmd_t C_NOP      = 5'd0;
	localparam cmd_t C_LATCH    = 5'd1;
	localparam cmd_t C_CLEAR    = 5'd2;
	localparam cmd_t C_EMPTY    = 5'd3;
	localparam cmd_t C_FULL     = 5'd4;
	localparam cmd_t C_GO_FIRST = 5'd5;
	localparam cmd_t C_GO_LAST  = 5'd6;
	localparam cmd_t C_OK       = 5'd7;
	localparam cmd_t C_INS_RD   = 5'd8;
	localparam cmd_t C_INS_LINK = 5'd9;
	localparam cmd_t C_INS_FIN  = 5'd10;
	localparam cmd_t C_DEL_RD   = 5'd11;
	localparam cmd_t C_DEL_FIN  = 5'd12;
	localparam cmd_t C_RD_RD    = 5'd13;
	localparam cmd_t C_RD_FIN   = 5'd14;
	localparam cmd_t C_MV_START = 5'd15;
	localparam cmd_t C_DIV      = 5'd16;
	localparam cmd_t C_MV_RD    = 5'd17;
	localparam cmd_t C_MV_STEP  = 5'd18;
	localparam cmd_t C_MV_LAST  = 5'd19;
	localparam cmd_t C_SR_START = 5'd20;
	localparam cmd_t C_SR_RD    = 5'd21;
	localparam cmd_t C_SR_STEP  = 5'd22;
	localparam cmd_t C_SR_HIT   = 5'd23;
	localparam cmd_t C_SR_MISS  = 5'd24;

	typedef struct packed {
		logic [2:0]         operation;
		logic               clear_request;
		logic [31:0]        data_value;
		logic signed [15:0] step_count;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] read_value;
		logic [8:0]  element_count;
	} rsp_t;

	typedef struct packed {
		logic [2:0] op;
		logic       clr;
		logic       cnt_zero;
		logic       full;
		logic       move_nop;
		logic       div_last;
		logic       k_zero;
		logic       k_one;
		logic       match;
		logic       out_valid;
	} stat_t;

endpackage

[hdl/circular_doubly_linked_list_cursor_unit.sv]
// Circular doubly linked list with a cursor and a pool of CAPACITY nodes.
// Request channel (req_valid/req_ready/req_data): one operation or a clear
// per request. Response channel (rsp_valid/rsp_ready/rsp_data): exactly one
// response per request, in order, with status, read value and node count.
// A request is taken only while the unit is idle; the response then sits in
// an output register, and the next request is taken while it waits.
// Clear, go first/last, full, empty and zero-step moves finish at decode;
// delete and read do one memory read first. A move reduces |steps| mod node
// count in a 16-bit restoring remainder unit, then does one link read per
// step; a search reads one node per step until a match or all are examined.
// Every node walk goes through the single read port of the link and value
// memories.
// Reset empties the list: count 0, cursor invalid, every node free. Node
// memories need no clearing, as a free-stack high-water mark stands in for
// the initial contents of the stack.
// A stalled receiver holds the finishing step until the response is taken.
module circular_doubly_linked_list_cursor_unit #(
	parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = cdll_pkg::VALUE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  cdll_pkg::req_t req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output cdll_pkg::rsp_t rsp_data
);
	import cdll_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	cdll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.req_ready (req_ready),
		.cmd       (cmd)
	);

	cdll_dpath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req_data  (req_data),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule

[hdl/cdll_ctrl.sv]
module cdll_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           rsp_ready,
	input  cdll_pkg::stat_t stat,
	output logic           req_ready,
	output cdll_pkg::cmd_t cmd
);
	import cdll_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_INS_L  = 4'd2;
	localparam logic [3:0] S_INS_F  = 4'd3;
	localparam logic [3:0] S_DEL_F  = 4'd4;
	localparam logic [3:0] S_RD_F   = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_MV_CHK = 4'd7;
	localparam logic [3:0] S_MV_RD  = 4'd8;
	localparam logic [3:0] S_MV_ST  = 4'd9;
	localparam logic [3:0] S_SR_RD  = 4'd10;
	localparam logic [3:0] S_SR_ST  = 4'd11;

	logic [3:0] state_q, state_d;
	cmd_t       cmd_d;
	logic       fin;
	logic       out_free;

	assign out_free  = !stat.out_valid || rsp_ready;
	assign req_ready = (state_q == S_IDLE);
	assign cmd       = cmd_d;

	always_comb begin
		state_d = state_q;
		cmd_d   = C_NOP;
		fin     = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd_d   = C_LATCH;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				state_d = S_IDLE;
				fin     = 1'b1;
				if (stat.clr) begin
					cmd_d = stat.cnt_zero ? C_EMPTY : C_CLEAR;
				end else begin
					case (stat.op)
						OP_INS_BEFORE, OP_INS_AFTER: begin
							if (stat.full) begin
								cmd_d = C_FULL;
							end else begin
								cmd_d   = C_INS_RD;
								fin     = 1'b0;
								state_d = S_INS_L;
							end
						end
						OP_GO_FIRST: cmd_d = C_GO_FIRST;
						OP_GO_LAST:  cmd_d = C_GO_LAST;
						default: begin
							if (stat.cnt_zero) begin
								cmd_d = C_EMPTY;
							end else begin
								case (stat.op)
									OP_DELETE: begin
										cmd_d   = C_DEL_RD;
										fin     = 1'b0;
										state_d = S_DEL_F;
									end
									OP_READ: begin
										cmd_d   = C_RD_RD;
										fin     = 1'b0;
										state_d = S_RD_F;
									end
									OP_MOVE: begin
										if (stat.move_nop) begin
											cmd_d = C_OK;
										end else begin
											cmd_d   = C_MV_START;
											fin     = 1'b0;
											state_d = S_DIV;
										end
									end
									default: begin
										cmd_d   = C_SR_START;
										fin     = 1'b0;
										state_d = S_SR_ST;
									end
								endcase
							end
						end
					endcase
				end
			end
			S_INS_L: begin
				cmd_d   = C_INS_LINK;
				state_d = S_INS_F;
			end
			S_INS_F: begin
				cmd_d   = C_INS_FIN;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_DEL_F: begin
				cmd_d   = C_DEL_FIN;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_RD_F: begin
				cmd_d   = C_RD_FIN;
				fin     = 1'b1;
				state_d = S_IDLE;
			end
			S_DIV: begin
				cmd_d = C_DIV;
				if (stat.div_last) begin
					state_d = S_MV_CHK;
				end
			end
			S_MV_CHK: begin
				if (stat.k_zero) begin
					cmd_d   = C_OK;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd_d   = C_MV_RD;
					state_d = S_MV_ST;
				end
			end
			S_MV_RD: begin
				cmd_d   = C_MV_RD;
				state_d = S_MV_ST;
			end
			S_MV_ST: begin
				if (stat.k_one) begin
					cmd_d   = C_MV_LAST;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd_d   = C_MV_STEP;
					state_d = S_MV_RD;
				end
			end
			S_SR_RD: begin
				cmd_d   = C_SR_RD;
				state_d = S_SR_ST;
			end
			S_SR_ST: begin
				if (stat.match) begin
					cmd_d   = C_SR_HIT;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else if (stat.k_one) begin
					cmd_d   = C_SR_MISS;
					fin     = 1'b1;
					state_d = S_IDLE;
				end else begin
					cmd_d   = C_SR_STEP;
					state_d = S_SR_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// hold the finishing step while the previous result is still unread
		if (fin && !out_free) begin
			cmd_d   = C_NOP;
			state_d = state_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/cdll_dpath.sv]
module cdll_dpath #(
	parameter int CAPACITY   = cdll_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = cdll_pkg::VALUE_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cdll_pkg::cmd_t  cmd,
	input  cdll_pkg::req_t  req_data,
	input  logic            rsp_ready,
	output cdll_pkg::stat_t stat,
	output logic            rsp_valid,
	output cdll_pkg::rsp_t  rsp_data
);
	import cdll_pkg::*;
	`include "assert_macros.svh"

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int VB = VALUE_BITS;

	logic [VB-1:0] val_mem [CAPACITY];
	logic [IW-1:0] nxt_mem [CAPACITY];
	logic [IW-1:0] prv_mem [CAPACITY];
	logic [IW-1:0] fs_mem  [CAPACITY];

	logic [VB-1:0] val_rd_q;
	logic [IW-1:0] nxt_rd_q, prv_rd_q, fs_rd_q;

	req_t          req_q;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, cursor_q, cursor_d;
	logic [CW-1:0] count_q, count_d, hw_q, hw_d, k_q, k_d;
	logic [IW-1:0] c_q, c_d, n_q, n_d, nb_q, nb_d;
	logic [15:0]   abs_q, abs_d;
	logic [3:0]    div_i_q, div_i_d;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	logic [VB-1:0] vin;
	logic          after, back, cnt_zero;
	logic [IW-1:0] n_new, nb_new, walk_nx, h2, t2;
	logic [CW:0]   rem_t;

	logic          val_re, lnk_re, fs_re;
	logic [IW-1:0] val_ra, lnk_ra;
	logic          val_we, nxt_we, prv_we, fs_we;
	logic [IW-1:0] val_wa, nxt_wa, prv_wa, fs_wa;
	logic [VB-1:0] val_wd;
	logic [IW-1:0] nxt_wd, prv_wd, fs_wd;
	logic          fin;
	logic [1:0]    res_st;
	logic [31:0]   res_val;

	assign vin      = VB'(req_q.data_value);
	assign after    = (req_q.operation == OP_INS_AFTER);
	assign back     = req_q.step_count[15];
	assign cnt_zero = (count_q == '0);
	// a stack slot at or above the high-water mark was never written and holds its own index
	assign n_new    = (count_q >= hw_q) ? count_q[IW-1:0] : fs_rd_q;
	assign nb_new   = after ? nxt_rd_q : prv_rd_q;
	assign walk_nx  = back ? prv_rd_q : nxt_rd_q;
	assign h2       = (prv_rd_q == tail_q) ? nxt_rd_q : head_q;
	assign t2       = (nxt_rd_q == h2) ? prv_rd_q : tail_q;
	assign rem_t    = {k_q, abs_q[div_i_q]};

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		cursor_d = cursor_q;
		count_d  = count_q;
		hw_d     = hw_q;
		k_d      = k_q;
		c_d      = c_q;
		n_d      = n_q;
		nb_d     = nb_q;
		abs_d    = abs_q;
		div_i_d  = div_i_q;
		val_re   = 1'b0;
		lnk_re   = 1'b0;
		fs_re    = 1'b0;
		val_ra   = cursor_q;
		lnk_ra   = cursor_q;
		val_we   = 1'b0;
		nxt_we   = 1'b0;
		prv_we   = 1'b0;
		fs_we    = 1'b0;
		val_wa   = n_new;
		nxt_wa   = n_new;
		prv_wa   = n_new;
		fs_wa    = count_q[IW-1:0];
		val_wd   = vin;
		nxt_wd   = n_new;
		prv_wd   = n_new;
		fs_wd    = cursor_q;
		fin      = 1'b0;
		res_st   = ST_OK;
		res_val  = '0;
		case (cmd)
			C_CLEAR: begin
				fin      = 1'b1;
				count_d  = '0;
				hw_d     = '0;
				head_d   = '0;
				tail_d   = '0;
				cursor_d = '0;
			end
			C_EMPTY: begin
				fin    = 1'b1;
				res_st = ST_EMPTY;
			end
			C_FULL: begin
				fin    = 1'b1;
				res_st = ST_FULL;
			end
			C_GO_FIRST: begin
				fin      = 1'b1;
				cursor_d = head_q;
			end
			C_GO_LAST: begin
				fin      = 1'b1;
				cursor_d = tail_q;
			end
			C_OK: fin = 1'b1;
			C_INS_RD: begin
				fs_re  = 1'b1;
				lnk_re = 1'b1;
			end
			C_INS_LINK: begin
				n_d    = n_new;
				nb_d   = nb_new;
				val_we = 1'b1;
				nxt_we = 1'b1;
				prv_we = 1'b1;
				if (!cnt_zero) begin
					nxt_wd = after ? nb_new : cursor_q;
					prv_wd = after ? cursor_q : nb_new;
				end
			end
			C_INS_FIN: begin
				fin      = 1'b1;
				nxt_we   = !cnt_zero;
				prv_we   = !cnt_zero;
				nxt_wa   = after ? cursor_q : nb_q;
				prv_wa   = after ? nb_q : cursor_q;
				nxt_wd   = n_q;
				prv_wd   = n_q;
				if (cnt_zero) begin
					head_d = n_q;
					tail_d = n_q;
				end else if (after) begin
					if (nb_q == head_q) tail_d = n_q;
				end else begin
					if (nb_q == tail_q) head_d = n_q;
				end
				cursor_d = n_q;
				count_d  = count_q + CW'(1);
				if (count_q == hw_q) hw_d = hw_q + CW'(1);
			end
			C_DEL_RD: lnk_re = 1'b1;
			C_DEL_FIN: begin
				fin     = 1'b1;
				nxt_we  = 1'b1;
				prv_we  = 1'b1;
				fs_we   = 1'b1;
				nxt_wa  = prv_rd_q;
				nxt_wd  = nxt_rd_q;
				prv_wa  = nxt_rd_q;
				prv_wd  = prv_rd_q;
				count_d = count_q - CW'(1);
				fs_wa   = count_d[IW-1:0];
				if (count_q == CW'(1)) begin
					head_d   = '0;
					tail_d   = '0;
					cursor_d = '0;
				end else begin
					head_d   = h2;
					tail_d   = t2;
					cursor_d = nxt_rd_q;
				end
			end
			C_RD_RD: val_re = 1'b1;
			C_RD_FIN: begin
				fin     = 1'b1;
				res_val = 32'(val_rd_q);
			end
			C_MV_START: begin
				c_d     = cursor_q;
				k_d     = '0;
				div_i_d = 4'd15;
				abs_d   = back ? 16'(-req_q.step_count) : 16'(req_q.step_count);
			end
			C_DIV: begin
				// one restoring step of |steps| mod node count
				k_d     = (rem_t >= {1'b0, count_q}) ? CW'(rem_t - {1'b0, count_q})
				                                   : CW'(rem_t);
				div_i_d = div_i_q - 4'd1;
			end
			C_MV_RD, C_SR_RD: begin
				lnk_re = 1'b1;
				val_re = (cmd == C_SR_RD);
				lnk_ra = c_q;
				val_ra = c_q;
			end
			C_MV_STEP: begin
				c_d = walk_nx;
				k_d = k_q - CW'(1);
			end
			C_MV_LAST: begin
				fin      = 1'b1;
				cursor_d = walk_nx;
			end
			C_SR_START: begin
				val_re = 1'b1;
				lnk_re = 1'b1;
				c_d    = cursor_q;
				k_d    = count_q;
			end
			C_SR_STEP: begin
				c_d = nxt_rd_q;
				k_d = k_q - CW'(1);
			end
			C_SR_HIT: begin
				fin      = 1'b1;
				cursor_d = c_q;
			end
			C_SR_MISS: begin
				fin    = 1'b1;
				res_st = ST_NOT_FOUND;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (val_we) val_mem[val_wa] <= val_wd;
		if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we) prv_mem[prv_wa] <= prv_wd;
		if (fs_we)  fs_mem[fs_wa]   <= fs_wd;
		if (val_re) val_rd_q <= val_mem[val_ra];
		if (lnk_re) begin
			nxt_rd_q <= nxt_mem[lnk_ra];
			prv_rd_q <= prv_mem[lnk_ra];
		end
		if (fs_re) fs_rd_q <= fs_mem[count_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd == C_LATCH) req_q <= req_data;
		k_q     <= k_d;
		c_q     <= c_d;
		n_q     <= n_d;
		nb_q    <= nb_d;
		abs_q   <= abs_d;
		div_i_q <= div_i_d;
		if (fin) begin
			rsp_q.status        <= res_st;
			rsp_q.read_value    <= res_val;
			rsp_q.element_count <= 9'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			tail_q      <= '0;
			cursor_q    <= '0;
			count_q     <= '0;
			hw_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			cursor_q <= cursor_d;
			count_q  <= count_d;
			hw_q     <= hw_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign stat.op        = req_q.operation;
	assign stat.clr       = req_q.clear_request;
	assign stat.cnt_zero  = cnt_zero;
	assign stat.full      = (count_q == CW'(CAPACITY));
	assign stat.move_nop  = (count_q < CW'(2)) || (req_q.step_count == '0);
	assign stat.div_last  = (div_i_q == 4'd0);
	assign stat.k_zero    = (k_q == '0);
	assign stat.k_one     = (k_q == CW'(1));
	assign stat.match     = (val_rd_q == vin);
	assign stat.out_valid = rsp_valid_q;

	`CDLL_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "node count above capacity")
	`CDLL_ASSERT(a_count_hw, count_q <= hw_q, "node count above free-stack high-water mark")
	`CDLL_ASSERT_NEXT(a_empty_regs, fin && (count_d == '0),
		(cursor_q == '0) && (head_q == '0) && (tail_q == '0), "empty list left stale pointers")

endmodule
